/* src/msq_pkg.sv */
package msq_pkg;

    localparam int SLOTS       = 64;
    localparam int HANDLE_BITS = 32;
    localparam int ID_W        = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);

    // action codes
    localparam logic [2:0] ACT_INSERT      = 3'd0;
    localparam logic [2:0] ACT_EXTRACT     = 3'd1;
    localparam logic [2:0] ACT_REMOVE      = 3'd2;
    localparam logic [2:0] ACT_REMOVE_HEAD = 3'd3;
    localparam logic [2:0] ACT_DEQUEUE     = 3'd4;
    localparam logic [2:0] ACT_LOOKUP      = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_BAD   = 2'd3;

    // slot states
    localparam logic [1:0] SLOT_FREE = 2'd0;
    localparam logic [1:0] SLOT_LIVE = 2'd1;
    localparam logic [1:0] SLOT_DEQ  = 2'd2;

    typedef struct packed {
        logic [2:0]             action;
        logic [ID_W-1:0]        slot_id;
        logic [HANDLE_BITS-1:0] handle;
    } cmd_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [ID_W-1:0]        result_id;
        logic [HANDLE_BITS-1:0] result_handle;
        logic [1:0]             slot_kind;
        logic [CNT_W-1:0]       unread_count;
        logic [CNT_W-1:0]       held_count;
    } result_t;

    typedef struct packed {
        logic       unread;
        logic [1:0] kind;
    } meta_t;

    typedef struct packed {
        logic issue;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic early;
    } dp_stat_t;

    typedef enum logic {
        CS_IDLE,
        CS_EXEC
    } ctrl_state_t;

endpackage

/* src/msq_ram.sv */
module msq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/msq_ctrl.sv */
module msq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  msq_pkg::dp_stat_t stat,
    output logic              busy,
    output msq_pkg::ctrl_cmd_t ctl
);

    msq_pkg::ctrl_state_t state_reg;
    msq_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msq_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b0;
        unique case (state_reg)
            msq_pkg::CS_IDLE:
            begin
                if (start)
                begin
                    ctl.issue = 1'b1;
                    if (!stat.early)
                    begin
                        state_next = msq_pkg::CS_EXEC;
                    end
                end
            end
            msq_pkg::CS_EXEC:
            begin
                busy       = 1'b1;
                ctl.exec   = 1'b1;
                state_next = msq_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

/* src/msq_dp.sv */
module msq_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [msq_pkg::CNT_W-1:0]        cfg_data,
    input  msq_pkg::cmd_t                    cmd,
    input  msq_pkg::ctrl_cmd_t               ctl,
    output msq_pkg::dp_stat_t                stat,
    output logic                             done,
    output msq_pkg::result_t                 result
);

    localparam int ID_W  = msq_pkg::ID_W;
    localparam int CNT_W = msq_pkg::CNT_W;
    localparam int HB    = msq_pkg::HANDLE_BITS;

    // list ends and counters
    logic [CNT_W-1:0] capacity_reg;
    logic [ID_W-1:0]  uh_reg, ut_reg, lh_reg, lt_reg;
    logic [ID_W-1:0]  uh_next, ut_next, lh_next, lt_next;
    logic             live_empty_reg, live_empty_next;
    logic [CNT_W-1:0] free_top_reg, free_top_next;
    logic [CNT_W-1:0] unread_total_reg, unread_total_next;
    logic [CNT_W-1:0] held_total_reg, held_total_next;
    logic [msq_pkg::SLOTS-1:0] meta_valid_reg;
    logic [msq_pkg::SLOTS-1:0] fs_valid_reg;
    logic             done_reg;

    // latched item
    logic [2:0]       op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [HB-1:0]    hin_reg;
    msq_pkg::result_t result_reg;

    // memory ports
    msq_pkg::meta_t   meta_rd, meta_wd, meta_eff;
    logic             meta_we;
    logic [ID_W-1:0]  meta_wa;
    logic [HB-1:0]    hs_rd;
    logic             hs_we;
    logic [ID_W-1:0]  hs_wa;
    logic [ID_W-1:0]  un_rd, up_rd, ln_rd, lp_rd, fs_rd;
    logic             un_we, up_we, ln_we, lp_we, fs_we;
    logic [ID_W-1:0]  un_wa, up_wa, ln_wa, lp_wa, fs_wa;
    logic [ID_W-1:0]  un_wd, up_wd, ln_wd, lp_wd, fs_wd;

    logic [ID_W-1:0]  rd_addr, fs_raddr, alloc_id, rel_id;
    logic [CNT_W-1:0] ft_dec, cap_gap, cap_sat;
    logic             in_range, unlink_u, unlink_l, release_en;
    logic [1:0]       early_status;
    msq_pkg::result_t early_res;
    msq_pkg::result_t res;

    assign ft_dec   = free_top_reg - CNT_W'(1);
    assign fs_raddr = ft_dec[ID_W-1:0];
    assign cap_gap  = capacity_reg - free_top_reg;
    assign in_range = {1'b0, cmd.slot_id} < capacity_reg;
    assign meta_eff = meta_valid_reg[id_reg] ? meta_rd : '0;
    assign alloc_id = fs_valid_reg[fs_raddr] ? fs_rd : cap_gap[ID_W-1:0];

    always_comb
    begin
        if (cfg_data == '0)
            cap_sat = CNT_W'(1);
        else if (cfg_data > CNT_W'(msq_pkg::SLOTS))
            cap_sat = CNT_W'(msq_pkg::SLOTS);
        else
            cap_sat = cfg_data;
    end

    // issue phase: pick the slot to read and catch items that finish at once
    always_comb
    begin
        stat.early   = 1'b0;
        early_status = msq_pkg::STAT_OK;
        unique case (cmd.action)
            msq_pkg::ACT_INSERT:
            begin
                if (free_top_reg == '0)
                begin
                    stat.early   = 1'b1;
                    early_status = msq_pkg::STAT_FULL;
                end
            end
            msq_pkg::ACT_EXTRACT:
            begin
                if (unread_total_reg == '0)
                begin
                    stat.early   = 1'b1;
                    early_status = msq_pkg::STAT_EMPTY;
                end
            end
            msq_pkg::ACT_REMOVE_HEAD:
            begin
                if (live_empty_reg)
                begin
                    stat.early   = 1'b1;
                    early_status = msq_pkg::STAT_EMPTY;
                end
            end
            msq_pkg::ACT_REMOVE, msq_pkg::ACT_DEQUEUE, msq_pkg::ACT_LOOKUP:
            begin
                if (!in_range)
                begin
                    stat.early   = 1'b1;
                    early_status = msq_pkg::STAT_BAD;
                end
            end
            default:
            begin
                stat.early   = 1'b1;
                early_status = msq_pkg::STAT_BAD;
            end
        endcase

        early_res              = '0;
        early_res.status       = early_status;
        early_res.unread_count = unread_total_reg;
        early_res.held_count   = held_total_reg;

        priority if (cmd.action == msq_pkg::ACT_REMOVE_HEAD)
            rd_addr = lh_reg;
        else if (cmd.action == msq_pkg::ACT_EXTRACT)
            rd_addr = uh_reg;
        else
            rd_addr = cmd.slot_id;
    end

    // execute phase
    always_comb
    begin
        uh_next = uh_reg;
        ut_next = ut_reg;
        lh_next = lh_reg;
        lt_next = lt_reg;
        live_empty_next   = live_empty_reg;
        free_top_next     = free_top_reg;
        unread_total_next = unread_total_reg;
        held_total_next   = held_total_reg;
        meta_we = 1'b0; meta_wa = id_reg; meta_wd = '0;
        hs_we = 1'b0;   hs_wa = id_reg;
        un_we = 1'b0;   un_wa = '0; un_wd = '0;
        up_we = 1'b0;   up_wa = '0; up_wd = '0;
        ln_we = 1'b0;   ln_wa = '0; ln_wd = '0;
        lp_we = 1'b0;   lp_wa = '0; lp_wd = '0;
        fs_we = 1'b0;   fs_wa = free_top_reg[ID_W-1:0]; fs_wd = id_reg;
        unlink_u = 1'b0;
        unlink_l = 1'b0;
        release_en = 1'b0;
        rel_id = id_reg;
        res = '0;
        res.status = msq_pkg::STAT_OK;

        if (ctl.exec)
        begin
            unique case (op_reg)
                msq_pkg::ACT_INSERT:
                begin
                    hs_we   = 1'b1;
                    hs_wa   = alloc_id;
                    meta_we = 1'b1;
                    meta_wa = alloc_id;
                    meta_wd = '{unread: 1'b1, kind: msq_pkg::SLOT_LIVE};
                    if (unread_total_reg == '0)
                        uh_next = alloc_id;
                    else
                    begin
                        un_we = 1'b1; un_wa = ut_reg; un_wd = alloc_id;
                        up_we = 1'b1; up_wa = alloc_id; up_wd = ut_reg;
                    end
                    ut_next = alloc_id;
                    if (live_empty_reg)
                        lh_next = alloc_id;
                    else
                    begin
                        ln_we = 1'b1; ln_wa = lt_reg; ln_wd = alloc_id;
                        lp_we = 1'b1; lp_wa = alloc_id; lp_wd = lt_reg;
                    end
                    lt_next = alloc_id;
                    live_empty_next   = 1'b0;
                    free_top_next     = ft_dec;
                    unread_total_next = unread_total_reg + CNT_W'(1);
                    held_total_next   = held_total_reg + CNT_W'(1);
                    res.result_id     = alloc_id;
                    res.result_handle = hin_reg;
                end
                msq_pkg::ACT_EXTRACT:
                begin
                    unlink_u = meta_eff.unread;
                    meta_we  = 1'b1;
                    meta_wd  = '{unread: 1'b0, kind: meta_eff.kind};
                    res.result_id     = id_reg;
                    res.result_handle = hs_rd;
                end
                msq_pkg::ACT_REMOVE, msq_pkg::ACT_REMOVE_HEAD, msq_pkg::ACT_DEQUEUE:
                begin
                    if (op_reg != msq_pkg::ACT_REMOVE_HEAD &&
                        meta_eff.kind != msq_pkg::SLOT_LIVE)
                        res.status = msq_pkg::STAT_BAD;
                    else
                    begin
                        unlink_u = meta_eff.unread;
                        unlink_l = 1'b1;
                        if (op_reg == msq_pkg::ACT_DEQUEUE)
                        begin
                            meta_we = 1'b1;
                            meta_wd = '{unread: 1'b0, kind: msq_pkg::SLOT_DEQ};
                        end
                        else
                            release_en = 1'b1;
                        res.result_id     = id_reg;
                        res.result_handle = hs_rd;
                    end
                end
                msq_pkg::ACT_LOOKUP:
                begin
                    res.result_id = id_reg;
                    res.slot_kind = meta_eff.kind;
                    if (meta_eff.kind != msq_pkg::SLOT_FREE)
                        res.result_handle = hs_rd;
                    if (meta_eff.kind == msq_pkg::SLOT_DEQ)
                        release_en = 1'b1;
                end
                default:
                begin
                    res.status = msq_pkg::STAT_BAD;
                end
            endcase

            // unread list unlink
            if (unlink_u)
            begin
                if (uh_reg == id_reg)
                    uh_next = un_rd;
                else
                begin
                    un_we = 1'b1; un_wa = up_rd; un_wd = un_rd;
                end
                if (ut_reg == id_reg)
                    ut_next = up_rd;
                else
                begin
                    up_we = 1'b1; up_wa = un_rd; up_wd = up_rd;
                end
                if (unread_total_reg != '0)
                    unread_total_next = unread_total_reg - CNT_W'(1);
            end

            // live list unlink
            if (unlink_l)
            begin
                if (lh_reg == id_reg)
                    lh_next = ln_rd;
                else
                begin
                    ln_we = 1'b1; ln_wa = lp_rd; ln_wd = ln_rd;
                end
                if (lt_reg == id_reg)
                    lt_next = lp_rd;
                else
                begin
                    lp_we = 1'b1; lp_wa = ln_rd; lp_wd = lp_rd;
                end
                if (lh_reg == id_reg && lt_reg == id_reg)
                    live_empty_next = 1'b1;
            end

            // slot back onto the free stack
            if (release_en)
            begin
                meta_we = 1'b1;
                meta_wd = '{unread: 1'b0, kind: msq_pkg::SLOT_FREE};
                if (free_top_reg < CNT_W'(msq_pkg::SLOTS))
                begin
                    fs_we = 1'b1;
                    fs_wd = rel_id;
                    free_top_next = free_top_reg + CNT_W'(1);
                end
                if (held_total_reg != '0)
                    held_total_next = held_total_reg - CNT_W'(1);
            end

            res.unread_count = unread_total_next;
            res.held_count   = held_total_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg     <= CNT_W'(msq_pkg::SLOTS);
            uh_reg           <= '0;
            ut_reg           <= '0;
            lh_reg           <= '0;
            lt_reg           <= '0;
            live_empty_reg   <= 1'b1;
            free_top_reg     <= CNT_W'(msq_pkg::SLOTS);
            unread_total_reg <= '0;
            held_total_reg   <= '0;
            meta_valid_reg   <= '0;
            fs_valid_reg     <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= !cfg_we && (ctl.exec || (ctl.issue && stat.early));
            if (cfg_we)
            begin
                capacity_reg     <= cap_sat;
                uh_reg           <= '0;
                ut_reg           <= '0;
                lh_reg           <= '0;
                lt_reg           <= '0;
                live_empty_reg   <= 1'b1;
                free_top_reg     <= cap_sat;
                unread_total_reg <= '0;
                held_total_reg   <= '0;
                meta_valid_reg   <= '0;
                fs_valid_reg     <= '0;
            end
            else if (ctl.exec)
            begin
                uh_reg           <= uh_next;
                ut_reg           <= ut_next;
                lh_reg           <= lh_next;
                lt_reg           <= lt_next;
                live_empty_reg   <= live_empty_next;
                free_top_reg     <= free_top_next;
                unread_total_reg <= unread_total_next;
                held_total_reg   <= held_total_next;
                if (meta_we)
                    meta_valid_reg[meta_wa] <= 1'b1;
                if (fs_we)
                    fs_valid_reg[fs_wa] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            op_reg  <= cmd.action;
            id_reg  <= rd_addr;
            hin_reg <= cmd.handle;
            if (stat.early)
            begin
                result_reg <= early_res;
            end
        end
        else if (ctl.exec)
        begin
            result_reg <= res;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    msq_ram #(.WIDTH($bits(msq_pkg::meta_t)), .DEPTH(msq_pkg::SLOTS)) u_meta (
        .clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
        .raddr(rd_addr), .rdata(meta_rd)
    );

    msq_ram #(.WIDTH(HB), .DEPTH(msq_pkg::SLOTS)) u_handle (
        .clk(clk), .we(hs_we), .waddr(hs_wa), .wdata(hin_reg),
        .raddr(rd_addr), .rdata(hs_rd)
    );

    msq_ram #(.WIDTH(ID_W), .DEPTH(msq_pkg::SLOTS)) u_unext (
        .clk(clk), .we(un_we), .waddr(un_wa), .wdata(un_wd),
        .raddr(rd_addr), .rdata(un_rd)
    );

    msq_ram #(.WIDTH(ID_W), .DEPTH(msq_pkg::SLOTS)) u_uprev (
        .clk(clk), .we(up_we), .waddr(up_wa), .wdata(up_wd),
        .raddr(rd_addr), .rdata(up_rd)
    );

    msq_ram #(.WIDTH(ID_W), .DEPTH(msq_pkg::SLOTS)) u_lnext (
        .clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd),
        .raddr(rd_addr), .rdata(ln_rd)
    );

    msq_ram #(.WIDTH(ID_W), .DEPTH(msq_pkg::SLOTS)) u_lprev (
        .clk(clk), .we(lp_we), .waddr(lp_wa), .wdata(lp_wd),
        .raddr(rd_addr), .rdata(lp_rd)
    );

    msq_ram #(.WIDTH(ID_W), .DEPTH(msq_pkg::SLOTS)) u_fstack (
        .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
        .raddr(fs_raddr), .rdata(fs_rd)
    );

endmodule

/* src/message_slot_queue_unit.sv */
// channel   | ports                 | handshake
// ----------+-----------------------+----------------------------------------
// command   | start, busy, cmd      | beat taken when start high, busy low
// result    | done, result          | done high for one cycle, cannot stall
// config    | cfg_we, cfg_data      | capacity written when cfg_we high
//
// an item with a fault found at accept (full, empty list, bad id, unknown
// action) gives its result registered at the accept edge, busy stays low
// any other item has a read cycle on the slot memories with registered read
// data, then an update cycle with busy high; its result is registered after that
// reset clears list ends, counters and the per-slot valid bits at once, so
// no clearing pass runs; a capacity write empties the table the same way
module message_slot_queue_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  msq_pkg::cmd_t                 cmd,
    // result channel
    output logic                          done,
    output msq_pkg::result_t              result,
    // capacity register
    input  logic                          cfg_we,
    input  logic [msq_pkg::CNT_W-1:0]     cfg_data
);

    // controller and datapath talk only through these
    msq_pkg::ctrl_cmd_t ctl;
    msq_pkg::dp_stat_t  stat;

    // sequencer: idle/accept, then an update cycle for items that touch memory
    msq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .ctl   (ctl)
    );

    // slot memories, list ends, free stack and counters
    msq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .ctl      (ctl),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

endmodule

/* tb/sv/message_slot_queue_unit_test.sv */
`timescale 1ns / 100ps

module message_slot_queue_unit_test;

    localparam int LIMIT_CYCLES = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    msq_pkg::cmd_t cmd = '0;
    logic done;
    msq_pkg::result_t result;
    logic cfg_we = 1'b0;
    logic [msq_pkg::CNT_W-1:0] cfg_data = '0;

    message_slot_queue_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // shadow copy of the slot table
    int unsigned          cap;
    logic [31:0]          sh_handle [msq_pkg::SLOTS];
    logic [1:0]           sh_state [msq_pkg::SLOTS];
    bit                   sh_unread [msq_pkg::SLOTS];
    int unsigned          un_next [msq_pkg::SLOTS], un_prev [msq_pkg::SLOTS];
    int unsigned          lv_next [msq_pkg::SLOTS], lv_prev [msq_pkg::SLOTS];
    int unsigned          un_head, un_tail, lv_head, lv_tail;
    bit                   lv_empty;
    int unsigned          free_ids [msq_pkg::SLOTS];
    int unsigned          free_depth;
    int unsigned          n_unread, n_held;

    msq_pkg::cmd_t    pending_cmds [$];
    msq_pkg::result_t expected_results [$];
    int      errors = 0;
    int      cycle_count = 0;
    bit      send_hold = 1'b0;  // sender pauses here while the table drains
    bit      bursts_on = 1'b1;
    int      gap_left = 0;
    logic    busy_at_rise = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want,
                 cycle_count);
        errors++;
    endtask

    function automatic void clear_table(input int unsigned c);
        cap = c;
        for (int i = 0; i < msq_pkg::SLOTS; i++)
        begin
            sh_state[i] = msq_pkg::SLOT_FREE;
            sh_unread[i] = 1'b0;
            free_ids[i] = 0;
        end
        for (int i = 0; i < c; i++)
            free_ids[i] = c - 1 - i;
        free_depth = c;
        un_head = 0; un_tail = 0; lv_head = 0; lv_tail = 0;
        lv_empty = 1'b1;
        n_unread = 0;
        n_held = 0;
    endfunction

    // unlink from the unread chain
    function automatic void unlink_unread(input int unsigned id);
        bit h, t;
        if (!sh_unread[id])
            return;
        sh_unread[id] = 1'b0;
        h = (un_head == id);
        t = (un_tail == id);
        if (h) un_head = un_next[id]; else un_next[un_prev[id]] = un_next[id];
        if (t) un_tail = un_prev[id]; else un_prev[un_next[id]] = un_prev[id];
        if (n_unread > 0) n_unread--;
    endfunction

    function automatic void unlink_live(input int unsigned id);
        bit h, t;
        h = (lv_head == id);
        t = (lv_tail == id);
        if (h) lv_head = lv_next[id]; else lv_next[lv_prev[id]] = lv_next[id];
        if (t) lv_tail = lv_prev[id]; else lv_prev[lv_next[id]] = lv_prev[id];
        if (h && t) lv_empty = 1'b1;
    endfunction

    function automatic void free_slot(input int unsigned id);
        sh_state[id] = msq_pkg::SLOT_FREE;
        if (free_depth < msq_pkg::SLOTS) free_ids[free_depth++] = id;
        if (n_held > 0) n_held--;
    endfunction

    function automatic msq_pkg::result_t predict_slot_op(input msq_pkg::cmd_t c);
        msq_pkg::result_t r;
        int unsigned id;
        bit ok_id;
        r = '0;
        ok_id = (c.slot_id < cap);
        case (c.action)
            msq_pkg::ACT_INSERT:
                if (free_depth == 0) r.status = msq_pkg::STAT_FULL;
                else
                begin
                    id = free_ids[--free_depth];
                    sh_handle[id] = c.handle;
                    sh_state[id] = msq_pkg::SLOT_LIVE;
                    if (n_unread == 0) un_head = id;
                    else
                    begin
                        un_next[un_tail] = id;
                        un_prev[id] = un_tail;
                    end
                    un_tail = id;
                    sh_unread[id] = 1'b1;
                    if (lv_empty) lv_head = id;
                    else
                    begin
                        lv_next[lv_tail] = id;
                        lv_prev[id] = lv_tail;
                    end
                    lv_tail = id;
                    lv_empty = 1'b0;
                    n_unread++;
                    n_held++;
                    r.result_id = msq_pkg::ID_W'(id);
                    r.result_handle = c.handle;
                end
            msq_pkg::ACT_EXTRACT:
                if (n_unread == 0) r.status = msq_pkg::STAT_EMPTY;
                else
                begin
                    id = un_head;
                    unlink_unread(id);
                    r.result_id = msq_pkg::ID_W'(id);
                    r.result_handle = sh_handle[id];
                end
            msq_pkg::ACT_REMOVE, msq_pkg::ACT_REMOVE_HEAD:
            begin
                if (c.action == msq_pkg::ACT_REMOVE_HEAD)
                begin
                    if (lv_empty) r.status = msq_pkg::STAT_EMPTY;
                    id = lv_head;
                end
                else
                begin
                    if (!ok_id || sh_state[c.slot_id] != msq_pkg::SLOT_LIVE)
                        r.status = msq_pkg::STAT_BAD;
                    id = c.slot_id;
                end
                if (r.status == msq_pkg::STAT_OK)
                begin
                    unlink_unread(id);
                    unlink_live(id);
                    free_slot(id);
                    r.result_id = msq_pkg::ID_W'(id);
                    r.result_handle = sh_handle[id];
                end
            end
            msq_pkg::ACT_DEQUEUE:
                if (!ok_id || sh_state[c.slot_id] != msq_pkg::SLOT_LIVE)
                    r.status = msq_pkg::STAT_BAD;
                else
                begin
                    unlink_unread(c.slot_id);
                    unlink_live(c.slot_id);
                    sh_state[c.slot_id] = msq_pkg::SLOT_DEQ;
                    r.result_id = c.slot_id;
                    r.result_handle = sh_handle[c.slot_id];
                end
            msq_pkg::ACT_LOOKUP:
                if (!ok_id) r.status = msq_pkg::STAT_BAD;
                else
                begin
                    r.result_id = c.slot_id;
                    r.slot_kind = sh_state[c.slot_id];
                    if (sh_state[c.slot_id] != msq_pkg::SLOT_FREE)
                        r.result_handle = sh_handle[c.slot_id];
                    if (sh_state[c.slot_id] == msq_pkg::SLOT_DEQ)
                        free_slot(c.slot_id);
                end
            default: r.status = msq_pkg::STAT_BAD;
        endcase
        r.unread_count = msq_pkg::CNT_W'(n_unread);
        r.held_count = msq_pkg::CNT_W'(n_held);
        return r;
    endfunction

    // driver: new beat offered at the falling edge once the last one was taken
    always @(negedge clk)
    begin
        if (rst_n && !(start && busy_at_rise))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_cmds.size() > 0 && !send_hold)
            begin
                cmd <= pending_cmds.pop_front();
                start <= 1'b1;
                if (bursts_on && $urandom_range(0, 5) == 0)
                    gap_left <= $urandom_range(1, 10);
            end
            else
                start <= 1'b0;
        end
    end

    // accept and result sampling at the rising edge
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        busy_at_rise <= busy;
        if (rst_n && start && !busy)
            expected_results.push_back(predict_slot_op(cmd));
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected beat", 64'(result), 64'd0);
            else
            begin
                msq_pkg::result_t w;
                w = expected_results.pop_front();
                if (result.status !== w.status)
                    report_mismatch("status", 64'(result.status), 64'(w.status));
                if (result.result_id !== w.result_id)
                    report_mismatch("result_id", 64'(result.result_id),
                                    64'(w.result_id));
                if (result.result_handle !== w.result_handle)
                    report_mismatch("result_handle", 64'(result.result_handle),
                                    64'(w.result_handle));
                if (result.slot_kind !== w.slot_kind)
                    report_mismatch("slot_kind", 64'(result.slot_kind),
                                    64'(w.slot_kind));
                if (result.unread_count !== w.unread_count)
                    report_mismatch("unread_count", 64'(result.unread_count),
                                    64'(w.unread_count));
                if (result.held_count !== w.held_count)
                    report_mismatch("held_count", 64'(result.held_count),
                                    64'(w.held_count));
            end
        end
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic msq_pkg::cmd_t mk(input logic [2:0] a, input int unsigned s,
                                         input logic [31:0] h);
        msq_pkg::cmd_t c;
        c.action = a;
        c.slot_id = msq_pkg::ID_W'(s);
        c.handle = h;
        return c;
    endfunction

    // wait until the queue is sent and every result is back, then settle
    task automatic drain();
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_capacity(input int unsigned v);
        @(negedge clk);
        cfg_data <= msq_pkg::CNT_W'(v);
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        clear_table(v < 1 ? 1 : (v > msq_pkg::SLOTS ? msq_pkg::SLOTS : v));
    endtask

    // mostly well formed traffic: insert-heavy, ids near live slots
    task automatic queue_random(input int n);
        msq_pkg::cmd_t c;
        for (int i = 0; i < n; i++)
        begin
            c.handle = $urandom;
            if ($urandom_range(0, 19) == 0)
                c.action = 3'($urandom_range(6, 7));
            else
                c.action = 3'($urandom_range(0, 5));
            if ($urandom_range(0, 3) == 0) c.action = msq_pkg::ACT_INSERT;
            if ($urandom_range(0, 4) == 0)
                c.slot_id = msq_pkg::ID_W'($urandom_range(0, 63));
            else
                c.slot_id = msq_pkg::ID_W'($urandom_range(0, 11));
            pending_cmds.push_back(c);
        end
    endtask

    initial
    begin
        clear_table(msq_pkg::SLOTS);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, extremes, every action, bad actions
        pending_cmds.push_back(mk(msq_pkg::ACT_EXTRACT, 0, 0));
        pending_cmds.push_back(mk(msq_pkg::ACT_REMOVE_HEAD, 0, 0));
        pending_cmds.push_back(mk(msq_pkg::ACT_LOOKUP, 63, 0));
        pending_cmds.push_back(mk(msq_pkg::ACT_REMOVE, 0, 0));
        pending_cmds.push_back(mk(msq_pkg::ACT_INSERT, 0, 32'hFFFF_FFFF));
        pending_cmds.push_back(mk(msq_pkg::ACT_INSERT, 0, 32'h0));
        pending_cmds.push_back(mk(msq_pkg::ACT_INSERT, 0, 32'h5A5A_A5A5));
        pending_cmds.push_back(mk(msq_pkg::ACT_EXTRACT, 0, 0));
        pending_cmds.push_back(mk(msq_pkg::ACT_DEQUEUE, 1, 0));
        pending_cmds.push_back(mk(msq_pkg::ACT_DEQUEUE, 1, 0));
        pending_cmds.push_back(mk(msq_pkg::ACT_REMOVE, 1, 0));
        pending_cmds.push_back(mk(msq_pkg::ACT_LOOKUP, 1, 0));
        pending_cmds.push_back(mk(msq_pkg::ACT_LOOKUP, 1, 0));
        pending_cmds.push_back(mk(msq_pkg::ACT_REMOVE_HEAD, 0, 0));
        pending_cmds.push_back(mk(msq_pkg::ACT_REMOVE, 2, 0));
        pending_cmds.push_back(mk(3'd6, 0, 0));
        pending_cmds.push_back(mk(3'd7, 63, 32'hFFFF_FFFF));
        drain();

        // capacity one: full table and out-of-range ids
        write_capacity(0);
        pending_cmds.push_back(mk(msq_pkg::ACT_INSERT, 0, 32'h1234_5678));
        pending_cmds.push_back(mk(msq_pkg::ACT_INSERT, 0, 32'h1));
        pending_cmds.push_back(mk(msq_pkg::ACT_LOOKUP, 1, 0));
        pending_cmds.push_back(mk(msq_pkg::ACT_DEQUEUE, 63, 0));
        queue_random(60);
        drain();

        write_capacity(127);
        queue_random(150);
        while (pending_cmds.size() > 75)
            @(posedge clk);
        send_hold = 1'b1;   // hold off until every result is back
        while (start || expected_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        send_hold = 1'b0;
        drain();
        queue_random(100);
        drain();

        write_capacity(5);
        queue_random(100);
        drain();

        write_capacity(64);
        bursts_on = 1'b0;   // closing stretch without gaps
        queue_random(90);
        drain();

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* sim.f */
src/msq_pkg.sv
src/msq_ram.sv
src/msq_ctrl.sv
src/msq_dp.sv
src/message_slot_queue_unit.sv
tb/sv/message_slot_queue_unit_test.sv
